// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl, included by ssi_encoder_quadrature_speed.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked every clock outside reset
`define SQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the clock after the antecedent
`define SQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SQS_ASSERT(lbl, prop, msg)
`define SQS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/sqs_pkg.sv =====
// types and constants for the ssi encoder quadrature and speed block
package sqs_pkg;

  localparam int unsigned FRAME_W    = 24;
  localparam int unsigned POS_OUT_W  = 16;
  localparam int unsigned ANGLE_W    = 19;
  localparam int unsigned SPEED_W    = 24;
  localparam int unsigned TS_W       = 20;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned PERIOD_W   = 10;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SPEED_Q    = 16;

  localparam logic [TS_W-1:0]    MS_WRAP    = 20'd999999;
  localparam logic [ANGLE_W-1:0] ANGLE_FULL = 19'd360000;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 24'hFFFFFF;

  localparam logic [SHIFT_W-1:0]  FRAME_SHIFT_RST = 4'd7;
  localparam logic [PERIOD_W-1:0] SNAP_PERIOD_RST = 10'd100;
  localparam logic [SCALE_W-1:0]  SPEED_SCALE_RST = 24'd600000;

  typedef enum logic {
    REQ_FRAME = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_SHIFT = 2'd0,
    CFG_SNAP_PERIOD = 2'd1,
    CFG_SPEED_SCALE = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/sqs_channels.sv =====
// request and result channel interfaces

interface sqs_in_if;
  import sqs_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [FRAME_W-1:0] ssi_frame;

  modport source (output valid, output req_type, output ssi_frame, input ready);
  modport sink   (input valid, input req_type, input ssi_frame, output ready);
endinterface

interface sqs_out_if;
  import sqs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] position;
  logic                 quad_a;
  logic                 quad_b;
  logic [ANGLE_W-1:0]   angle_mdeg;
  logic [SPEED_W-1:0]   speed_mrpm;
  logic                 report;
  logic [TS_W-1:0]      timestamp_ms;

  modport source (output valid, output position, output quad_a, output quad_b,
                  output angle_mdeg, output speed_mrpm, output report,
                  output timestamp_ms, input ready);
  modport sink   (input valid, input position, input quad_a, input quad_b,
                  input angle_mdeg, input speed_mrpm, input report,
                  input timestamp_ms, output ready);
endinterface

// ===== rtl/ssi_encoder_quadrature_speed.sv =====
// ssi encoder gray decode, quadrature emulation, angle and speed report
// an accepted request passes the decode stage register, then the math stage into the result register
// throughput: one request per cycle while the result is taken; the multipliers of the math stage set the path
// a stalled result holds the output register while the decode stage takes one more request
// reset (synchronous, rst_n low): position, snapshot, period count and timestamp clear,
// registers return to frame_shift 7, snapshot_period 100, speed_scale 600000
`include "assert_macros.svh"

module ssi_encoder_quadrature_speed
  import sqs_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sqs_in_if.sink                in_chan,
  sqs_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned P        = POSITION_BITS;
  localparam int unsigned SPROD_W  = P + SCALE_W;
  localparam int unsigned APROD_W  = P + ANGLE_W;

  // configuration registers
  logic [SHIFT_W-1:0]  frame_shift_r;
  logic [PERIOD_W-1:0] snap_period_r;
  logic [SCALE_W-1:0]  speed_scale_r;

  // block state
  logic [P-1:0]        cur_pos_r, cur_pos_nxt;
  logic [P-1:0]        snap_pos_r, snap_pos_nxt;
  logic [PERIOD_W-1:0] period_cnt_r, period_cnt_nxt;
  logic [TS_W-1:0]     ms_cnt_r, ms_cnt_nxt;
  logic                report_nxt;

  // decode stage
  logic                s1_valid_r;
  logic [P-1:0]        s1_pos_r;
  logic [P-1:0]        s1_snap_r;
  logic                s1_report_r;
  logic [TS_W-1:0]     s1_ms_r;

  // result register
  logic                 out_valid_r;
  logic [POS_OUT_W-1:0] out_pos_r;
  logic                 out_qa_r;
  logic                 out_qb_r;
  logic [ANGLE_W-1:0]   out_angle_r;
  logic [SPEED_W-1:0]   out_speed_r;
  logic                 out_report_r;
  logic [TS_W-1:0]      out_ms_r;

  logic                in_fire;
  logic                is_tick;
  logic                adv;
  logic                tick_report;
  logic [FRAME_W-1:0]  frame_shr;
  logic [P-1:0]        gray_raw;
  logic [P-1:0]        bin_pos;
  logic [PERIOD_W-1:0] period_inc;

  logic [P-1:0]        delta;
  logic [SPROD_W-1:0]  speed_prod;
  logic [31:0]         speed_shr;
  logic [SPEED_W-1:0]  speed_sat;
  logic [APROD_W-1:0]  angle_prod;
  logic [ANGLE_W-1:0]  angle_val;
  logic [1:0]          quad_code;

  // handshake
  assign adv            = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = adv || !s1_valid_r;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign is_tick        = (req_type_t'(in_chan.req_type) == REQ_TICK);
  assign tick_report    = in_fire && report_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_shift_r <= FRAME_SHIFT_RST;
      snap_period_r <= SNAP_PERIOD_RST;
      speed_scale_r <= SPEED_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_SHIFT: frame_shift_r <= cfg_data[SHIFT_W-1:0];
        CFG_SNAP_PERIOD: snap_period_r <= cfg_data[PERIOD_W-1:0];
        CFG_SPEED_SCALE: speed_scale_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // align frame and gray decode: each bit is the xor of its gray bit and all bits above it
  assign frame_shr = in_chan.ssi_frame >> frame_shift_r;
  assign gray_raw  = frame_shr[P-1:0];

  always_comb begin
    for (int i = 0; i < P; i++) begin
      bin_pos[i] = ^(gray_raw >> i);
    end
  end

  // state update on an accepted request
  assign period_inc = period_cnt_r + 1'b1;

  always_comb begin
    cur_pos_nxt    = cur_pos_r;
    snap_pos_nxt   = snap_pos_r;
    period_cnt_nxt = period_cnt_r;
    ms_cnt_nxt     = ms_cnt_r;
    report_nxt     = 1'b0;
    if (in_fire) begin
      if (!is_tick) begin
        cur_pos_nxt = bin_pos;
      end else begin
        ms_cnt_nxt = (ms_cnt_r >= MS_WRAP) ? '0 : ms_cnt_r + 1'b1;
        // a zero period reports on every tick, as does a wrapped count
        if (period_inc >= snap_period_r || period_inc == '0) begin
          period_cnt_nxt = '0;
          report_nxt     = 1'b1;
          snap_pos_nxt   = cur_pos_r;
        end else begin
          period_cnt_nxt = period_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r    <= '0;
      snap_pos_r   <= '0;
      period_cnt_r <= '0;
      ms_cnt_r     <= '0;
    end else begin
      cur_pos_r    <= cur_pos_nxt;
      snap_pos_r   <= snap_pos_nxt;
      period_cnt_r <= period_cnt_nxt;
      ms_cnt_r     <= ms_cnt_nxt;
    end
  end

  // decode stage register, speed measured against the snapshot before update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos_r    <= cur_pos_nxt;
      s1_snap_r   <= snap_pos_r;
      s1_report_r <= report_nxt;
      s1_ms_r     <= ms_cnt_nxt;
    end
  end

  // quadrature: codes 2 and 3 swap so the pair steps as gray code
  assign quad_code = {s1_pos_r[2], s1_pos_r[2] ^ s1_pos_r[1]};

  // angle in millidegrees
  assign angle_prod = APROD_W'(s1_pos_r) * APROD_W'(ANGLE_FULL);
  assign angle_val  = ANGLE_W'(angle_prod >> P);

  // speed in milli-rpm, q16 scale, saturated
  assign delta      = s1_pos_r - s1_snap_r;
  assign speed_prod = SPROD_W'(delta) * SPROD_W'(speed_scale_r);
  assign speed_shr  = 32'(speed_prod >> SPEED_Q);
  assign speed_sat  = (|speed_shr[31:SPEED_W]) ? SPEED_MAX : speed_shr[SPEED_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_pos_r    <= POS_OUT_W'(s1_pos_r);
      out_qa_r     <= quad_code[1];
      out_qb_r     <= quad_code[0];
      out_angle_r  <= angle_val;
      out_speed_r  <= speed_sat;
      out_report_r <= s1_report_r;
      out_ms_r     <= s1_ms_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.position     = out_pos_r;
  assign out_chan.quad_a       = out_qa_r;
  assign out_chan.quad_b       = out_qb_r;
  assign out_chan.angle_mdeg   = out_angle_r;
  assign out_chan.speed_mrpm   = out_speed_r;
  assign out_chan.report       = out_report_r;
  assign out_chan.timestamp_ms = out_ms_r;

  // checks
  `SQS_ASSERT(a_ms_range, ms_cnt_r <= MS_WRAP, "timestamp beyond wrap value")
  `SQS_ASSERT_NEXT(a_snap_take, tick_report, snap_pos_r == $past(cur_pos_r), "snapshot not taken on report")
  `SQS_ASSERT(a_snap_only_on_report, ($past(rst_n) && snap_pos_r != $past(snap_pos_r)) |-> $past(tick_report), "snapshot moved without report")
  `SQS_ASSERT(a_stall_only_full, !in_chan.ready |-> (s1_valid_r && out_valid_r && !out_chan.ready), "request stalled with room free")

endmodule
